[hw/rtl/ppc_pkg.sv]
// Package for the permutation property checker: store size, derived widths,
// sequencer state type and the flag word. No dependencies.
`default_nettype none

package ppc_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int VALUE_W     = 16;
    localparam int LENGTH_W    = 9;

    // Entry value limit as a 16-bit pattern, for the store range check.
    localparam logic [VALUE_W-1:0] STORE_LIMIT = VALUE_W'(MAX_ENTRIES);

    typedef enum logic [9:0] {
        ST_LOAD      = 10'b0000000001,
        ST_SCAN_RD   = 10'b0000000010,
        ST_SCAN_MARK = 10'b0000000100,
        ST_SCAN_CHK  = 10'b0000001000,
        ST_WALK_PICK = 10'b0000010000,
        ST_WALK_TEST = 10'b0000100000,
        ST_WALK_RD   = 10'b0001000000,
        ST_WALK_CHK  = 10'b0010000000,
        ST_FINISH    = 10'b0100000000,
        ST_CLEAR     = 10'b1000000000
    } ppc_state_t;

    // Flags gathered while the map loads.
    typedef struct packed {
        logic fits;    // every entry lies inside the store range
        logic ident;   // every entry equals its position
        logic same;    // every entry equals the first one
    } ppc_flags_t;

    localparam ppc_flags_t FLAGS_ALL = '{fits: 1'b1, ident: 1'b1, same: 1'b1};

endpackage

`default_nettype wire

[hw/rtl/ppc_if.sv]
// Valid/ready channels of the permutation property checker: the entry
// channel and the result channel. Depends on ppc_pkg.
`default_nettype none

interface ppc_in_if
    import ppc_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] entry_value;
    logic                      last_entry;

    modport source (output valid, output entry_value, output last_entry, input ready);
    modport sink   (input valid, input entry_value, input last_entry, output ready);
endinterface

interface ppc_out_if
    import ppc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [LENGTH_W-1:0] map_length;
    logic                all_in_range;
    logic                is_bijection;
    logic                is_even;
    logic                is_identity;
    logic                is_constant;

    modport source (output valid, output map_length, output all_in_range,
                    output is_bijection, output is_even, output is_identity,
                    output is_constant, input ready);
    modport sink   (input valid, input map_length, input all_in_range,
                    input is_bijection, input is_even, input is_identity,
                    input is_constant, output ready);
endinterface

`default_nettype wire

[hw/rtl/permutation_property_checker.sv]
// Top level of the permutation property checker: load, scan, cycle walk.
// Depends on ppc_pkg and the channel interfaces in ppc_if.sv.
`default_nettype none

// The block takes a map of n entries, one word per cycle on entry_in, and the
// word with last_entry set (or the MAX_ENTRIES-th word) closes the map. It
// then answers with one word on result_out: n and five flags (all entries in
// 0..n-1, bijection, even permutation, identity, all entries equal). While a
// map loads, entry_in is ready every cycle. After the last word entry_in drops
// ready while one shared sequencer works through the entry store and a mark
// bitmap, both RAMs with one registered read a cycle. A scan (entry read, mark
// read, check) checks range and repeats and sets the mark of each value seen.
// Then, for a bijection only, a cycle walk (a mark read and a test at each
// start position, a read and a check for each visited entry, one last look
// past the end) counts even-length cycles for the parity and clears each mark
// as its position is visited. A map that is not a bijection but was scanned
// leaves marks behind: a clearing pass wipes them after the result is handed
// over. After reset the block is not ready while it clears the whole mark
// bitmap. The result sits in an output register; the next map may load while
// it waits to be taken.
module permutation_property_checker
    import ppc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ppc_in_if.sink    entry_in,
    ppc_out_if.source result_out
);

    // Sequencer and per-map state.
    ppc_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [VALUE_W-1:0] first_reg, first_next;
    ppc_flags_t         flags_reg, flags_next;
    logic               range_ok_reg, range_ok_next;
    logic               dup_reg, dup_next;
    logic               len_odd_reg, len_odd_next;
    logic               parity_reg, parity_next;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    logic [LENGTH_W-1:0] out_length_reg, out_length_next;
    logic                out_range_reg, out_range_next;
    logic                out_bij_reg, out_bij_next;
    logic                out_even_reg, out_even_next;
    logic                out_ident_reg, out_ident_next;
    logic                out_const_reg, out_const_next;

    // Entry store: one write port for loading, one registered read port.
    logic [IDX_W-1:0] entry_store [MAX_ENTRIES];
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] rd_data_reg;
    logic             wr_en;

    // Mark bitmap: set for each value seen in the scan, cleared again as the
    // walk visits that position, so a bijection leaves it all zero.
    logic             mark_mem [MAX_ENTRIES];
    logic [IDX_W-1:0] mark_rd_addr;
    logic             mark_rd_reg;
    logic             mark_wr_en;
    logic [IDX_W-1:0] mark_wr_addr;
    logic             mark_wr_data;
    logic             marks_dirty;

    logic             in_fire;
    logic             out_fire;
    logic             in_store;
    logic             map_end;
    logic [CNT_W-1:0] pos_inc;
    logic [VALUE_W-1:0] value_bits;

    assign value_bits = $unsigned(entry_in.entry_value);
    assign in_fire    = entry_in.valid && entry_in.ready;
    assign out_fire   = result_out.valid && result_out.ready;
    assign in_store   = !value_bits[VALUE_W-1] && (value_bits < STORE_LIMIT);
    assign pos_inc    = pos_reg + CNT_W'(1);
    assign map_end    = entry_in.last_entry || (pos_inc == CNT_W'(MAX_ENTRIES));
    assign wr_en      = in_fire && in_store;

    assign entry_in.ready = (state_reg == ST_LOAD);

    assign result_out.valid        = out_valid_reg;
    assign result_out.map_length   = out_length_reg;
    assign result_out.all_in_range = out_range_reg;
    assign result_out.is_bijection = out_bij_reg;
    assign result_out.is_even      = out_even_reg;
    assign result_out.is_identity  = out_ident_reg;
    assign result_out.is_constant  = out_const_reg;

    // Read the scan position while scanning, the walk cursor otherwise.
    assign rd_addr = ((state_reg == ST_SCAN_RD) || (state_reg == ST_SCAN_MARK)) ?
                     idx_reg[IDX_W-1:0] : j_reg;

    // Look up the start position when picking, the value just read otherwise.
    assign mark_rd_addr = (state_reg == ST_WALK_PICK) ? idx_reg[IDX_W-1:0] : rd_data_reg;

    // A scanned map that skipped the walk leaves marks set.
    assign marks_dirty = flags_reg.fits && !(range_ok_reg && !dup_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_store[pos_reg[IDX_W-1:0]] <= value_bits[IDX_W-1:0];
        end
        rd_data_reg <= entry_store[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mark_wr_en)
        begin
            mark_mem[mark_wr_addr] <= mark_wr_data;
        end
        mark_rd_reg <= mark_mem[mark_rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        n_next          = n_reg;
        idx_next        = idx_reg;
        j_next          = j_reg;
        first_next      = first_reg;
        flags_next      = flags_reg;
        range_ok_next   = range_ok_reg;
        dup_next        = dup_reg;
        len_odd_next    = len_odd_reg;
        parity_next     = parity_reg;
        out_valid_next  = out_valid_reg;
        out_length_next = out_length_reg;
        out_range_next  = out_range_reg;
        out_bij_next    = out_bij_reg;
        out_even_next   = out_even_reg;
        out_ident_next  = out_ident_reg;
        out_const_next  = out_const_reg;
        mark_wr_en      = 1'b0;
        mark_wr_addr    = rd_data_reg;
        mark_wr_data    = 1'b0;

        // Drop the result once the sink takes it.
        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    // Update the running flags with this word.
                    if (pos_reg == '0)
                    begin
                        first_next = value_bits;
                    end
                    else if (value_bits != first_reg)
                    begin
                        flags_next.same = 1'b0;
                    end
                    if (!in_store)
                    begin
                        flags_next.fits = 1'b0;
                    end
                    if (value_bits != VALUE_W'(pos_reg))
                    begin
                        flags_next.ident = 1'b0;
                    end
                    pos_next = pos_inc;
                    if (map_end)
                    begin
                        n_next        = pos_inc;
                        idx_next      = '0;
                        range_ok_next = flags_next.fits;
                        dup_next      = 1'b0;
                        // Skip the scan when some word already missed the store.
                        state_next    = flags_next.fits ? ST_SCAN_RD : ST_FINISH;
                    end
                end
            end

            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_MARK;
            end

            ST_SCAN_MARK:
            begin
                state_next = ST_SCAN_CHK;
            end

            ST_SCAN_CHK:
            begin
                if ({1'b0, rd_data_reg} >= n_reg)
                begin
                    range_ok_next = 1'b0;
                end
                else if (mark_rd_reg)
                begin
                    dup_next = 1'b1;
                end
                else
                begin
                    mark_wr_en   = 1'b1;
                    mark_wr_addr = rd_data_reg;
                    mark_wr_data = 1'b1;
                end
                idx_next = idx_reg + CNT_W'(1);
                if (idx_next == n_reg)
                begin
                    idx_next   = '0;
                    state_next = (range_ok_next && !dup_next) ? ST_WALK_PICK : ST_FINISH;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end

            ST_WALK_PICK:
            begin
                if (idx_reg == n_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_WALK_TEST;
                end
            end

            ST_WALK_TEST:
            begin
                if (!mark_rd_reg)
                begin
                    // Already visited by an earlier cycle.
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_WALK_PICK;
                end
                else
                begin
                    // Open a new cycle at this position.
                    j_next       = idx_reg[IDX_W-1:0];
                    len_odd_next = 1'b0;
                    state_next   = ST_WALK_RD;
                end
            end

            ST_WALK_RD:
            begin
                mark_wr_en   = 1'b1;
                mark_wr_addr = j_reg;
                mark_wr_data = 1'b0;
                len_odd_next = !len_odd_reg;
                state_next   = ST_WALK_CHK;
            end

            ST_WALK_CHK:
            begin
                if (rd_data_reg == idx_reg[IDX_W-1:0])
                begin
                    // Back at the start: an even length flips the parity.
                    if (!len_odd_reg)
                    begin
                        parity_next = !parity_reg;
                    end
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_WALK_PICK;
                end
                else
                begin
                    j_next     = rd_data_reg;
                    state_next = ST_WALK_RD;
                end
            end

            ST_FINISH:
            begin
                // Hold until the output register is free, then hand over and clear.
                if (!out_valid_reg || out_fire)
                begin
                    out_valid_next  = 1'b1;
                    out_length_next = LENGTH_W'(n_reg);
                    out_range_next  = range_ok_reg;
                    out_bij_next    = range_ok_reg && !dup_reg;
                    out_even_next   = range_ok_reg && !dup_reg && !parity_reg;
                    out_ident_next  = flags_reg.ident;
                    out_const_next  = flags_reg.same;
                    pos_next        = '0;
                    idx_next        = '0;
                    first_next      = '0;
                    flags_next      = FLAGS_ALL;
                    parity_next     = 1'b0;
                    state_next      = marks_dirty ? ST_CLEAR : ST_LOAD;
                end
            end

            ST_CLEAR:
            begin
                // Wipe marks 0..n-1, one a cycle.
                mark_wr_en   = 1'b1;
                mark_wr_addr = idx_reg[IDX_W-1:0];
                mark_wr_data = 1'b0;
                idx_next     = idx_reg + CNT_W'(1);
                if (idx_next == n_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_LOAD;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            pos_reg       <= '0;
            n_reg         <= CNT_W'(MAX_ENTRIES);
            idx_reg       <= '0;
            j_reg         <= '0;
            first_reg     <= '0;
            flags_reg     <= FLAGS_ALL;
            range_ok_reg  <= 1'b0;
            dup_reg       <= 1'b0;
            len_odd_reg   <= 1'b0;
            parity_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            j_reg         <= j_next;
            first_reg     <= first_next;
            flags_reg     <= flags_next;
            range_ok_reg  <= range_ok_next;
            dup_reg       <= dup_next;
            len_odd_reg   <= len_odd_next;
            parity_reg    <= parity_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload: loaded only together with the valid flag.
    always_ff @(posedge clk)
    begin
        out_length_reg <= out_length_next;
        out_range_reg  <= out_range_next;
        out_bij_reg    <= out_bij_next;
        out_even_reg   <= out_even_next;
        out_ident_reg  <= out_ident_next;
        out_const_reg  <= out_const_next;
    end

endmodule

`default_nettype wire

[bench/map_verdict_scoreboard.sv]
// Scoreboard for the permutation property checker bench: predicts the verdict
// word for each closed map and checks the words the block returns.
// Depends on ppc_pkg.

package map_verdict_scoreboard_pkg;

    import ppc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [VALUE_W-1:0] entry_word_t;

    typedef struct packed {
        logic [LENGTH_W-1:0] map_length;
        logic                all_in_range;
        logic                is_bijection;
        logic                is_even;
        logic                is_identity;
        logic                is_constant;
    } map_verdict_t;

    class map_verdict_scoreboard;

        entry_word_t  open_map[$];
        map_verdict_t awaited_verdicts[$];
        int           failures;
        int           verdicts_checked;

        function new();
            failures         = 0;
            verdicts_checked = 0;
        endfunction

        // Work out the verdict for the map held in open_map.
        function map_verdict_t judge_map();
            map_verdict_t verdict;
            int           n;
            int           image;
            int           walk;
            int           span;
            int           even_cycles;
            bit           seen[MAX_ENTRIES];
            bit           visited[MAX_ENTRIES];

            n = open_map.size();
            foreach (seen[k])
            begin
                seen[k]    = 1'b0;
                visited[k] = 1'b0;
            end
            verdict.map_length   = LENGTH_W'(n);
            verdict.all_in_range = 1'b1;
            verdict.is_identity  = 1'b1;
            verdict.is_constant  = 1'b1;
            for (int pos = 0; pos < n; pos++)
            begin
                image = int'(open_map[pos]);
                if (image < 0 || image >= n)
                    verdict.all_in_range = 1'b0;
                if (image != pos)
                    verdict.is_identity = 1'b0;
                if (open_map[pos] !== open_map[0])
                    verdict.is_constant = 1'b0;
            end

            verdict.is_bijection = verdict.all_in_range;
            for (int pos = 0; pos < n && verdict.is_bijection; pos++)
            begin
                image = int'(open_map[pos]);
                if (seen[image])
                    verdict.is_bijection = 1'b0;
                else
                    seen[image] = 1'b1;
            end

            // Parity: even iff the count of even-length cycles is even.
            even_cycles = 0;
            if (verdict.is_bijection)
            begin
                for (int pos = 0; pos < n; pos++)
                begin
                    if (!visited[pos])
                    begin
                        walk = pos;
                        span = 0;
                        while (!visited[walk])
                        begin
                            visited[walk] = 1'b1;
                            walk          = int'(open_map[walk]);
                            span++;
                        end
                        if (span % 2 == 0)
                            even_cycles++;
                    end
                end
            end
            verdict.is_even = verdict.is_bijection && (even_cycles % 2 == 0);
            return verdict;
        endfunction

        // Note one accepted entry word; a closed map queues its verdict.
        function void take_entry(entry_word_t value, logic last);
            open_map.push_back(value);
            if (last || open_map.size() == MAX_ENTRIES)
            begin
                awaited_verdicts.push_back(judge_map());
                open_map.delete();
            end
        endfunction

        function void compare_field(string field, int expected_value, int actual_value);
            if (expected_value != actual_value)
            begin
                failures++;
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, field, expected_value, actual_value);
            end
        endfunction

        // Check one accepted verdict word against the oldest prediction.
        function void check_verdict(map_verdict_t got);
            map_verdict_t want;

            if (awaited_verdicts.size() == 0)
            begin
                failures++;
                $display("%0t ns: unexpected verdict, expected none, actual %h",
                         $time, got);
                return;
            end
            want = awaited_verdicts.pop_front();
            verdicts_checked++;
            compare_field("map_length",   want.map_length,   got.map_length);
            compare_field("all_in_range", want.all_in_range, got.all_in_range);
            compare_field("is_bijection", want.is_bijection, got.is_bijection);
            compare_field("is_even",      want.is_even,      got.is_even);
            compare_field("is_identity",  want.is_identity,  got.is_identity);
            compare_field("is_constant",  want.is_constant,  got.is_constant);
        endfunction

        function int pending();
            return awaited_verdicts.size();
        endfunction

    endclass

endpackage

[bench/permutation_property_checker_tb.sv]
// Top-level bench for the permutation property checker: directed and random
// maps, random stalls on both channels, checking through the scoreboard.
// Depends on ppc_pkg, ppc_if.sv and map_verdict_scoreboard.sv.

module permutation_property_checker_tb;

    import ppc_pkg::*;
    import map_verdict_scoreboard_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET    = 1650;
    // Items near the end go out with no idling on either side.
    localparam int QUIET_ITEMS    = 250;
    // Long receiver hold-off, enough for the block to finish the next map
    // and back up into the entry channel.
    localparam int HOLD_CYCLES    = 2400;
    localparam int HOLD_AT_WORD   = 45;
    // Wait after the last word, scaled to the work for a map of MAX_ENTRIES.
    localparam int DRAIN_CYCLES   = 7 * MAX_ENTRIES + 16;
    localparam int SETTLE_LIMIT   = 100000;

    typedef enum int {
        SHAPE_PERMUTATION,
        SHAPE_IDENTITY,
        SHAPE_CONSTANT,
        SHAPE_DAMAGED,
        SHAPE_NOISE
    } map_shape_e;

    logic clk = 1'b0;
    logic rst_n;

    ppc_in_if  entry_ch ();
    ppc_out_if result_ch ();

    permutation_property_checker dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .entry_in   (entry_ch),
        .result_out (result_ch)
    );

    map_verdict_scoreboard verdict_board;

    int          items_sent       = 0;
    int          source_calm_left = 0;
    bit          quiet_tail       = 1'b0;
    bit          long_hold_active = 1'b0;
    bit          long_hold_done   = 1'b0;
    entry_word_t map_q[$];

    always #10 clk = ~clk;

    // Watch both channels at the rising edge: a word moves when valid and
    // ready are both high.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (entry_ch.valid && entry_ch.ready)
                verdict_board.take_entry(entry_ch.entry_value, entry_ch.last_entry);
            if (result_ch.valid && result_ch.ready)
                verdict_board.check_verdict({result_ch.map_length, result_ch.all_in_range,
                                             result_ch.is_bijection, result_ch.is_even,
                                             result_ch.is_identity, result_ch.is_constant});
        end
    end

    // Hold the entry channel idle for a number of cycles.
    task automatic idle_source(int cycles);
        @(negedge clk);
        entry_ch.valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Insert a random idle burst, unless in a calm stretch, the quiet tail,
    // or while the receiver is holding off (keep pushing words then).
    task automatic maybe_idle_source();
        if (quiet_tail || long_hold_active)
            return;
        if (source_calm_left > 0)
            source_calm_left--;
        else if ($urandom_range(0, 29) == 0)
            source_calm_left = $urandom_range(30, 120);
        else if ($urandom_range(0, 5) == 0)
            idle_source($urandom_range(1, 12));
    endtask

    // Offer one entry word and wait for the block to take it.
    task automatic send_word(entry_word_t value, logic last);
        @(negedge clk);
        entry_ch.valid       <= 1'b1;
        entry_ch.entry_value <= value;
        entry_ch.last_entry  <= last;
        @(posedge clk);
        while (!entry_ch.ready)
            @(posedge clk);
        items_sent++;
        if (items_sent >= ITEM_TARGET - QUIET_ITEMS)
            quiet_tail = 1'b1;
    endtask

    // Send the words of map_q; close marks the final word.
    task automatic send_map(bit close);
        for (int i = 0; i < map_q.size(); i++)
        begin
            maybe_idle_source();
            send_word(map_q[i], (i == map_q.size() - 1) ? close : 1'b0);
        end
    endtask

    // Drop valid and wait until every verdict owed has come back.
    task automatic drain_verdicts();
        @(negedge clk);
        entry_ch.valid <= 1'b0;
        while (verdict_board.pending() != 0)
            @(negedge clk);
    endtask

    // Fill map_q with a random map of n entries of the given shape.
    task automatic build_map(int n, map_shape_e shape);
        int          spot;
        int          pick;
        entry_word_t swap_word;
        entry_word_t fill_word;

        map_q.delete();
        for (int i = 0; i < n; i++)
            map_q.push_back(entry_word_t'(i));
        case (shape)
            SHAPE_PERMUTATION, SHAPE_DAMAGED:
            begin
                for (int i = n - 1; i > 0; i--)
                begin
                    pick       = $urandom_range(0, i);
                    swap_word  = map_q[i];
                    map_q[i]   = map_q[pick];
                    map_q[pick] = swap_word;
                end
                if (shape == SHAPE_DAMAGED)
                begin
                    // Break one entry: repeat another, step just out of range, go
                    // negative, take the top store value, or land anywhere.
                    spot = $urandom_range(0, n - 1);
                    case ($urandom_range(0, 4))
                        0: map_q[spot] = map_q[$urandom_range(0, n - 1)];
                        1: map_q[spot] = entry_word_t'(n);
                        2: map_q[spot] = entry_word_t'(-1);
                        3: map_q[spot] = entry_word_t'(MAX_ENTRIES - 1);
                        default: map_q[spot] = entry_word_t'($urandom_range(0, 65535));
                    endcase
                end
            end
            SHAPE_CONSTANT:
            begin
                if ($urandom_range(0, 1) == 0)
                    fill_word = entry_word_t'($urandom_range(0, n - 1));
                else
                    fill_word = entry_word_t'($urandom_range(0, 65535));
                foreach (map_q[i])
                    map_q[i] = fill_word;
            end
            SHAPE_NOISE:
            begin
                foreach (map_q[i])
                    if ($urandom_range(0, 1) == 0)
                        map_q[i] = entry_word_t'($urandom_range(0, 65535));
                    else
                        map_q[i] = entry_word_t'($urandom_range(0, n + 2));
            end
            default: ;
        endcase
    endtask

    // Result side: random ready bursts, calm stretches, one long hold-off.
    initial
    begin
        int calm_left;

        calm_left       = 0;
        result_ch.ready = 1'b0;
        while (rst_n !== 1'b1)
            @(negedge clk);
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && verdict_board.verdicts_checked >= HOLD_AT_WORD)
            begin
                result_ch.ready  <= 1'b0;
                long_hold_active = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                long_hold_active = 1'b0;
                long_hold_done   = 1'b1;
            end
            else if (quiet_tail)
                result_ch.ready <= 1'b1;
            else if (calm_left > 0)
            begin
                calm_left--;
                result_ch.ready <= 1'b1;
            end
            else if ($urandom_range(0, 39) == 0)
            begin
                calm_left = $urandom_range(20, 80);
                result_ch.ready <= 1'b1;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge clk);
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Stimulus: reset, directed maps, random maps, drain and verdict.
    initial
    begin
        int         map_index;
        int         n;
        int         roll;
        int         settle;
        bit         close;
        map_shape_e shape;

        verdict_board        = new();
        rst_n                = 1'b0;
        entry_ch.valid       = 1'b0;
        entry_ch.entry_value = '0;
        entry_ch.last_entry  = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed maps: single identity, odd swap, even three-entry rotation, two
        // swaps, both value extremes, negative, just past the store, top of
        // the store, constant out of map range, and a repeat.
        map_q = {16'h0000};                         send_map(1'b1);
        map_q = {16'h0001, 16'h0000};               send_map(1'b1);
        map_q = {16'h0001, 16'h0002, 16'h0000};     send_map(1'b1);
        map_q = {16'h0001, 16'h0000, 16'h0003, 16'h0002};
        send_map(1'b1);
        map_q = {16'h8000, 16'h7FFF};               send_map(1'b1);
        map_q = {16'hFFFF};                         send_map(1'b1);
        map_q = {16'h0100};                         send_map(1'b1);
        map_q = {16'h00FF};                         send_map(1'b1);
        map_q = {16'h0005, 16'h0005, 16'h0005};     send_map(1'b1);
        map_q = {16'h0001, 16'h0001, 16'h0000};     send_map(1'b1);

        // Let every owed verdict come back once before the random part.
        drain_verdicts();

        map_index = 0;
        while (items_sent < ITEM_TARGET)
        begin
            // Mostly short maps; a few full-length ones, including maps that
            // close on the length limit with no last flag.
            roll = $urandom_range(0, 99);
            if (map_index == 4 || map_index == 12 || roll >= 98)
                n = MAX_ENTRIES;
            else if (roll < 70)
                n = $urandom_range(1, 8);
            else if (roll < 90)
                n = $urandom_range(9, 32);
            else
                n = $urandom_range(33, 100);
            if (items_sent + n > ITEM_TARGET && n == MAX_ENTRIES)
                n = $urandom_range(1, 8);

            roll = $urandom_range(0, 99);
            if (roll < 55)
                shape = SHAPE_PERMUTATION;
            else if (roll < 63)
                shape = SHAPE_IDENTITY;
            else if (roll < 70)
                shape = SHAPE_CONSTANT;
            else if (roll < 88)
                shape = SHAPE_DAMAGED;
            else
                shape = SHAPE_NOISE;

            if (n == MAX_ENTRIES)
                close = (map_index == 4) ? 1'b0 : (map_index == 12) ? 1'b1
                                                : 1'($urandom_range(0, 1));
            else
                close = 1'b1;

            build_map(n, shape);
            send_map(close);
            map_index++;

            // Now and then let every owed verdict come back before going on.
            if (map_index % 40 == 30 && !long_hold_active && !quiet_tail)
                drain_verdicts();
        end

        @(negedge clk);
        entry_ch.valid      <= 1'b0;
        entry_ch.last_entry <= 1'b0;

        settle = 0;
        while (verdict_board.pending() != 0 && settle < SETTLE_LIMIT)
        begin
            @(posedge clk);
            settle++;
        end
        // Catch any stray word the block might still produce.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (verdict_board.pending() != 0)
            $display("%0t ns: %0d verdicts never arrived, expected 0 outstanding",
                     $time, verdict_board.pending());

        if (verdict_board.failures == 0 && verdict_board.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
